// File: rtl/clws_pkg.sv
package clws_pkg;

	// request kinds
	localparam logic [1:0] KIND_COMMAND = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_CURSOR  = 2'd2;
	localparam logic [1:0] KIND_NUMBER  = 2'd3;

	// configuration register indexes
	localparam logic REG_BUS_MODE    = 1'b0;
	localparam logic REG_PULSE_TICKS = 1'b1;

	localparam int TICK_W = 24;
	localparam int NUM_W  = 32;
	localparam int MAG_W  = NUM_W + 2;  // room for 8 * 10^9

	localparam logic [TICK_W-1:0] PULSE_TICKS_RST = 24'd50000;
	localparam logic [7:0] CURSOR_CMD  = 8'h80;
	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;
	localparam logic [3:0] TOP_DIGIT   = 4'd9;

	typedef struct packed {
		logic load;   // take the request on the input
		logic conv;   // one restoring step of the decimal conversion
		logic emit;   // send the next pin event of byte_q
	} dp_cmd_t;

	typedef struct packed {
		logic start_conv;  // request is a non-negative integer
		logic digit_out;   // this conversion step loaded a digit byte
		logic byte_done;   // final pin event of the byte went out
		logic final_byte;  // byte in flight ends the request
	} dp_stat_t;

	function automatic logic [7:0] row_offset(input logic [1:0] r);
		logic [7:0] o;
		case (r)
			2'd0:    o = 8'd0;
			2'd1:    o = 8'd64;
			2'd2:    o = 8'd20;
			default: o = 8'd84;
		endcase
		return o;
	endfunction

	// 10^pos scaled by 2^wt, for BCD restoring conversion
	function automatic logic [MAG_W-1:0] pow10_scaled(input logic [3:0] pos,
		input logic [1:0] wt);
		logic [MAG_W-1:0] p;
		case (pos)
			4'd0:    p = 34'd1;
			4'd1:    p = 34'd10;
			4'd2:    p = 34'd100;
			4'd3:    p = 34'd1000;
			4'd4:    p = 34'd10000;
			4'd5:    p = 34'd100000;
			4'd6:    p = 34'd1000000;
			4'd7:    p = 34'd10000000;
			4'd8:    p = 34'd100000000;
			4'd9:    p = 34'd1000000000;
			default: p = '0;
		endcase
		return p << wt;
	endfunction

endpackage

// File: rtl/clws_if.sv
interface clws_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [7:0]        byte_value;
	logic [2:0]        row;
	logic [4:0]        column;
	logic signed [31:0] number;

	modport source (output valid, kind, byte_value, row, column, number, input ready);
	modport sink   (input valid, kind, byte_value, row, column, number, output ready);
endinterface

interface clws_evt_if;
	logic        valid;
	logic        ready;
	logic        reg_select;
	logic        read_write;
	logic        enable;
	logic [7:0]  bus_data;
	logic [23:0] hold_ticks;
	logic        last;

	modport source (output valid, reg_select, read_write, enable, bus_data, hold_ticks,
		last, input ready);
	modport sink   (input valid, reg_select, read_write, enable, bus_data, hold_ticks,
		last, output ready);
endinterface

// File: rtl/clws_datapath.sv
module clws_datapath #(
	parameter int MAX_COLUMNS = 20,
	parameter int MAX_ROWS    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  clws_pkg::dp_cmd_t   cmd,
	output clws_pkg::dp_stat_t  stat,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [23:0]         cfg_data,
	input  logic [1:0]          kind,
	input  logic [7:0]          byte_value,
	input  logic [2:0]          row,
	input  logic [4:0]          column,
	input  logic signed [31:0]  number,
	output logic                evt_valid,
	input  logic                evt_ready,
	output logic                reg_select,
	output logic                read_write,
	output logic                enable,
	output logic [7:0]          bus_data,
	output logic [23:0]         hold_ticks,
	output logic                last
);

	logic                           bus_mode_q;
	logic [clws_pkg::TICK_W-1:0]    pulse_ticks_q;

	logic [7:0]                     byte_q;
	logic                           rs_q;
	logic                           final_q;
	logic [clws_pkg::NUM_W-1:0]     mag_q;
	logic [3:0]                     pos_q;
	logic [1:0]                     wt_q;
	logic [3:0]                     dig_q;
	logic                           lead_q;
	logic [1:0]                     ev_q;

	logic                           ovalid_q;
	logic                           o_rs_q;
	logic                           o_en_q;
	logic [7:0]                     o_bus_q;
	logic                           o_last_q;

	logic                           cursor_ok;
	logic [7:0]                     cursor_cmd;
	logic [clws_pkg::NUM_W-1:0]     num_mag;
	logic [clws_pkg::MAG_W-1:0]     cand;
	logic                           ge;
	logic [3:0]                     dig_next;
	logic                           digit_fin;
	logic                           show;
	logic [1:0]                     last_ev;
	logic                           push;

	always_comb begin
		cursor_ok = (row != 3'd0) && (row <= 3'(MAX_ROWS)) && (column != 5'd0) &&
			({1'b0, column} <= 6'(MAX_COLUMNS));
		cursor_cmd = cursor_ok ?
			8'(clws_pkg::CURSOR_CMD + clws_pkg::row_offset(2'(row - 3'd1)) +
			{3'b000, column} - 8'd1) : clws_pkg::CURSOR_CMD;
		num_mag = number[31] ? (32'd0 - $unsigned(number)) : $unsigned(number);

		cand      = clws_pkg::pow10_scaled(pos_q, wt_q);
		ge        = {2'b00, mag_q} >= cand;
		dig_next  = ge ? (dig_q | (4'b0001 << wt_q)) : dig_q;
		digit_fin = (wt_q == 2'd0);
		show      = (dig_next != 4'd0) || !lead_q || (pos_q == 4'd0);

		last_ev = bus_mode_q ? 2'd3 : 2'd1;
		push    = cmd.emit && (!ovalid_q || evt_ready);

		stat.start_conv = (kind == clws_pkg::KIND_NUMBER) && !number[31];
		stat.digit_out  = cmd.conv && digit_fin && show;
		stat.byte_done  = push && (ev_q == last_ev);
		stat.final_byte = final_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_mode_q    <= 1'b0;
			pulse_ticks_q <= clws_pkg::PULSE_TICKS_RST;
			ovalid_q      <= 1'b0;
			ev_q          <= 2'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					clws_pkg::REG_BUS_MODE:    bus_mode_q    <= cfg_data[0];
					clws_pkg::REG_PULSE_TICKS: pulse_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (push)
				ovalid_q <= 1'b1;
			else if (evt_ready)
				ovalid_q <= 1'b0;
			if (cmd.load)
				ev_q <= 2'd0;
			else if (push)
				ev_q <= (ev_q == last_ev) ? 2'd0 : 2'(ev_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (kind)
				clws_pkg::KIND_COMMAND,
				clws_pkg::KIND_DATA: begin
					byte_q  <= byte_value;
					rs_q    <= (kind == clws_pkg::KIND_DATA);
					final_q <= 1'b1;
				end
				clws_pkg::KIND_CURSOR: begin
					byte_q  <= cursor_cmd;
					rs_q    <= 1'b0;
					final_q <= 1'b1;
				end
				default: begin
					mag_q   <= num_mag;
					pos_q   <= clws_pkg::TOP_DIGIT;
					wt_q    <= 2'd3;
					dig_q   <= 4'd0;
					lead_q  <= 1'b1;
					byte_q  <= clws_pkg::ASCII_MINUS;
					rs_q    <= 1'b1;
					final_q <= 1'b0;
				end
			endcase
		end else if (cmd.conv) begin
			if (ge)
				mag_q <= mag_q - cand[clws_pkg::NUM_W-1:0];
			if (digit_fin) begin
				wt_q  <= 2'd3;
				dig_q <= 4'd0;
				if (pos_q != 4'd0)
					pos_q <= pos_q - 4'd1;
				if (show) begin
					byte_q  <= clws_pkg::ASCII_ZERO + {4'b0000, dig_next};
					rs_q    <= 1'b1;
					final_q <= (pos_q == 4'd0);
					lead_q  <= 1'b0;
				end
			end else begin
				wt_q  <= wt_q - 2'd1;
				dig_q <= dig_next;
			end
		end

		if (push) begin
			o_rs_q   <= rs_q;
			o_en_q   <= ~ev_q[0];
			o_bus_q  <= bus_mode_q ?
				{4'b0000, (ev_q[1] ? byte_q[3:0] : byte_q[7:4])} : byte_q;
			o_last_q <= final_q && (ev_q == last_ev);
		end
	end

	// config must be written only while idle (the block does not enforce this), so hold_ticks stays stable under stall
	assign hold_ticks = (pulse_ticks_q == '0) ? 24'd1 : pulse_ticks_q;
	assign evt_valid  = ovalid_q;
	assign reg_select = o_rs_q;
	assign read_write = 1'b0;
	assign enable     = o_en_q;
	assign bus_data   = o_bus_q;
	assign last       = o_last_q;

endmodule

// File: rtl/clws_ctrl.sv
module clws_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output clws_pkg::dp_cmd_t   cmd,
	input  clws_pkg::dp_stat_t  stat
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.start_conv ? ST_CONV : ST_EMIT;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				if (stat.digit_out)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.byte_done)
					state_d = stat.final_byte ? ST_IDLE : ST_CONV;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: rtl/char_lcd_write_sequencer_unit.sv
// Sequence: a byte or cursor request loads byte_q when accepted; its first pin event
// moves into the output register once the controller is in emit and that register is
// free. A non-negative integer first runs conversion steps down to its leading digit,
// a negative one sends its '-' first. Rate: one pin event per cycle while emitting and
// the receiver is ready; integers convert over 10 places, one BCD restoring step a cycle.
// Reset (arst_n low, async): bus 8-bit, pulse_ticks 50000, sequencer idle, no beat held.
module char_lcd_write_sequencer_unit #(
	parameter int MAX_COLUMNS = 20,
	parameter int MAX_ROWS    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	clws_req_if.sink      req,
	clws_evt_if.source    evt,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [23:0]   cfg_data
);

	// Controller: idle -> (convert <-> emit)* -> idle.
	// Only one request is in flight; req.ready is high in idle only. The
	// output register decouples the last beat from the next request.
	clws_pkg::dp_cmd_t  cmd;
	clws_pkg::dp_stat_t stat;

	clws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Datapath: config regs, cursor address calc, decimal digit extraction
	// (restoring against 8/4/2/1 x 10^pos, MSD first, leading zeros
	// dropped), and nibble/byte event generation into the output register.
	clws_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.kind       (req.kind),
		.byte_value (req.byte_value),
		.row        (req.row),
		.column     (req.column),
		.number     (req.number),
		.evt_valid  (evt.valid),
		.evt_ready  (evt.ready),
		.reg_select (evt.reg_select),
		.read_write (evt.read_write),
		.enable     (evt.enable),
		.bus_data   (evt.bus_data),
		.hold_ticks (evt.hold_ticks),
		.last       (evt.last)
	);

endmodule

// File: rtl/clws_checker.sv
module clws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_rw,
	input logic        out_en,
	input logic        out_last,
	input logic [23:0] out_hold
);

	// a stalled beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted back to back");

	// every request ends on an E-low event
	a_last_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_en |-> !out_last)
		else $error("last beat with enable high");

	a_rw_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_rw && out_hold != 24'd0)
		else $error("bad RW or zero hold");

endmodule

bind char_lcd_write_sequencer_unit clws_checker u_clws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (evt.valid),
	.out_ready (evt.ready),
	.out_rw    (evt.read_write),
	.out_en    (evt.enable),
	.out_last  (evt.last),
	.out_hold  (evt.hold_ticks)
);

// File: sim/tb_char_lcd_write_sequencer_unit.sv
module tb_char_lcd_write_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// One request beat as the sender drives it
	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         byte_value;
		logic [2:0]         row;
		logic [4:0]         column;
		logic signed [31:0] number;
	} lcd_req_t;

	// One pin event as it leaves on the output channel
	typedef struct packed {
		logic        reg_select;
		logic        read_write;
		logic        enable;
		logic [7:0]  bus_data;
		logic [23:0] hold_ticks;
		logic        last;
	} pin_evt_t;

	localparam int ROWS_USED  = 4;
	localparam int COLS_USED  = 20;
	localparam int IDLE_LIMIT = 5000;  // cycles with no beat on either side
	localparam int LONG_HOLD  = 400;   // receiver back-pressure stretch
	localparam int TAIL_WAIT  = 100;   // worst integer conversion plus margin

	// Predicts the pin events of each accepted request and checks them in order.
	class lcd_pin_predictor;
		pin_evt_t    pins_due[$];
		logic        nibble_bus;
		logic [23:0] pulse_len;
		int          errors;

		function new();
			nibble_bus = 1'b0;
			pulse_len  = clws_pkg::PULSE_TICKS_RST;
			errors     = 0;
		endfunction

		function void set_reg(logic idx, logic [23:0] value);
			if (idx == clws_pkg::REG_BUS_MODE) begin
				nibble_bus = value[0];
			end else begin
				pulse_len = value;
			end
		endfunction

		// one byte: E high then E low, once per byte or once per nibble
		function void queue_byte(logic rs, logic [7:0] b);
			logic [7:0] part [2];
			int         parts;
			pin_evt_t   e;
			parts   = nibble_bus ? 2 : 1;
			part[0] = nibble_bus ? {4'h0, b[7:4]} : b;
			part[1] = {4'h0, b[3:0]};
			for (int p = 0; p < parts; p++) begin
				for (int k = 0; k < 2; k++) begin
					e.reg_select = rs;
					e.read_write = 1'b0;
					e.enable     = (k == 0);
					e.bus_data   = part[p];
					e.hold_ticks = (pulse_len == 24'd0) ? 24'd1 : pulse_len;
					e.last       = 1'b0;
					pins_due.push_back(e);
				end
			end
		endfunction

		function void note_request(lcd_req_t r);
			logic [7:0]  cmd;
			logic [7:0]  row_base [4];
			logic [31:0] mag;
			logic [3:0]  digs [10];
			int          nd;
			row_base = '{8'd0, 8'd64, 8'd20, 8'd84};
			case (r.kind)
				clws_pkg::KIND_COMMAND: queue_byte(1'b0, r.byte_value);
				clws_pkg::KIND_DATA:    queue_byte(1'b1, r.byte_value);
				clws_pkg::KIND_CURSOR: begin
					cmd = clws_pkg::CURSOR_CMD;
					if (r.row >= 1 && r.row <= ROWS_USED && r.column >= 1 &&
						r.column <= COLS_USED) begin
						cmd = clws_pkg::CURSOR_CMD + row_base[r.row - 1] +
							{3'd0, r.column} - 8'd1;
					end
					queue_byte(1'b0, cmd);
				end
				default: begin
					mag = r.number;
					if (mag[31]) begin
						queue_byte(1'b1, clws_pkg::ASCII_MINUS);
						mag = 32'd0 - mag;
					end
					nd = 0;
					do begin
						digs[nd] = 4'(mag % 32'd10);
						nd++;
						mag = mag / 32'd10;
					end while (mag != 0);
					for (int i = nd - 1; i >= 0; i--) begin
						queue_byte(1'b1, clws_pkg::ASCII_ZERO + {4'h0, digs[i]});
					end
				end
			endcase
			pins_due[pins_due.size() - 1].last = 1'b1;
		endfunction

		function void check_pin(pin_evt_t got);
			pin_evt_t want;
			if (pins_due.size() == 0) begin
				errors++;
				$display("%0t: pin event with nothing pending: %s%0d %s%0d",
					$time, "rs=", got.reg_select, "rw=", got.read_write);
				$display("%0t:   e=%0d data=%02h hold=%0d last=%0d",
					$time, got.enable, got.bus_data, got.hold_ticks, got.last);
				return;
			end
			want = pins_due.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: pin event mismatch: expected rs=%0d rw=%0d e=%0d %s%02h %s%0d %s%0d",
					$time, want.reg_select, want.read_write, want.enable, "data=",
					want.bus_data, "hold=", want.hold_ticks, "last=", want.last);
				$display("%0t:                     actual   rs=%0d rw=%0d e=%0d %s%02h %s%0d %s%0d",
					$time, got.reg_select, got.read_write, got.enable, "data=",
					got.bus_data, "hold=", got.hold_ticks, "last=", got.last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [23:0] cfg_data;

	clws_req_if req_ch ();
	clws_evt_if evt_ch ();

	char_lcd_write_sequencer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.evt       (evt_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lcd_pin_predictor book;
	bit no_idle;       // last part of the run: both sides at full rate
	bit hold_request;  // ask the receiver for one long back-pressure stretch
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: counts cycles in which neither channel moves a beat.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Receiver: checks each accepted beat at the rising edge, then decides
	// ready for the next cycle at the falling edge. Stalls come in bursts;
	// a long hold is counted here so the sender keeps pushing meanwhile.
	initial begin
		int hold_left;
		int stall_left;
		hold_left  = 0;
		stall_left = 0;
		evt_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (evt_ch.valid && evt_ch.ready) begin
				book.check_pin({evt_ch.reg_select, evt_ch.read_write, evt_ch.enable,
					evt_ch.bus_data, evt_ch.hold_ticks, evt_ch.last});
			end
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				evt_ch.ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				evt_ch.ready = 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				// this cycle is the first of a stall; stall_left counts the rest
				stall_left   = $urandom_range(0, 15);
				evt_ch.ready = 1'b0;
			end else begin
				evt_ch.ready = 1'b1;
			end
		end
	end

	function automatic lcd_req_t make_req(logic [1:0] kind, logic [7:0] b, logic [2:0] r,
		logic [4:0] c, logic signed [31:0] n);
		lcd_req_t q;
		q.kind       = kind;
		q.byte_value = b;
		q.row        = r;
		q.column     = c;
		q.number     = n;
		return q;
	endfunction

	// Random request. Unused fields are random too so every input bit toggles.
	// Cursor positions are mostly on screen; numbers lean toward digit-count
	// boundaries and the ends of the range.
	function automatic lcd_req_t random_req();
		lcd_req_t    q;
		logic [31:0] p10 [10];
		int          sel;
		p10 = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
			32'd10000000, 32'd100000000, 32'd1000000000};
		q.kind       = 2'($urandom_range(0, 3));
		q.byte_value = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) != 0) begin
			q.row = 3'($urandom_range(1, 4));
		end else begin
			q.row = 3'($urandom_range(0, 7));
		end
		if ($urandom_range(0, 3) != 0) begin
			q.column = 5'($urandom_range(1, 20));
		end else begin
			q.column = 5'($urandom_range(0, 31));
		end
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			q.number = $urandom;
		end else if (sel < 7) begin
			q.number = $urandom_range(0, 999);
		end else if (sel == 7) begin
			q.number = p10[$urandom_range(0, 9)] - $urandom_range(0, 1);
		end else if (sel == 8) begin
			case ($urandom_range(0, 3))
				0:       q.number = 32'sh80000000;
				1:       q.number = 32'sh7FFFFFFF;
				2:       q.number = 32'sd0;
				default: q.number = -32'sd1;
			endcase
		end else begin
			q.number = $urandom_range(0, 9);
		end
		if (sel >= 4 && sel != 8 && $urandom_range(0, 1) == 1) begin
			q.number = -q.number;
		end
		return q;
	endfunction

	// Offer one request; returns right after the edge that accepts it.
	// valid stays high into the next request unless a gap is inserted.
	task automatic send_request(lcd_req_t q);
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req_ch.kind       = q.kind;
		req_ch.byte_value = q.byte_value;
		req_ch.row        = q.row;
		req_ch.column     = q.column;
		req_ch.number     = q.number;
		req_ch.valid      = 1'b1;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		book.note_request(q);
	endtask

	task automatic send_random(int count);
		repeat (count) send_request(random_req());
	endtask

	// Stop offering and wait for every predicted pin event to leave, so a
	// register write lands while the block is idle.
	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (book.pins_due.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [23:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		book.set_reg(idx, value);
	endtask

	initial begin
		book         = new();
		no_idle      = 1'b0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = clws_pkg::REG_BUS_MODE;
		cfg_data     = 24'd0;
		req_ch.valid      = 1'b0;
		req_ch.kind       = clws_pkg::KIND_COMMAND;
		req_ch.byte_value = 8'd0;
		req_ch.row        = 3'd0;
		req_ch.column     = 5'd0;
		req_ch.number     = 32'sd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset settings: 8-bit bus, 50000-tick pulses.
		// Byte extremes for commands, alternating bit patterns for data.
		send_request(make_req(clws_pkg::KIND_COMMAND, 8'h00, 3'd7, 5'd31, 32'sh7FFFFFFF));
		send_request(make_req(clws_pkg::KIND_COMMAND, 8'hFF, 3'd0, 5'd0, 32'sh80000000));
		send_request(make_req(clws_pkg::KIND_DATA, 8'h5A, 3'd5, 5'd10, -32'sd1));
		send_request(make_req(clws_pkg::KIND_DATA, 8'hA5, 3'd2, 5'd21, 32'sd0));
		// Cursor: all four row offsets, column ends, then off-screen rows
		// and columns that fall back to the home command.
		send_request(make_req(clws_pkg::KIND_CURSOR, 8'h00, 3'd1, 5'd1, 32'sd0));
		send_request(make_req(clws_pkg::KIND_CURSOR, 8'hFF, 3'd2, 5'd5, -32'sd1));
		send_request(make_req(clws_pkg::KIND_CURSOR, 8'h00, 3'd3, 5'd20, 32'sd0));
		send_request(make_req(clws_pkg::KIND_CURSOR, 8'h00, 3'd4, 5'd20, 32'sd0));
		send_request(make_req(clws_pkg::KIND_CURSOR, 8'h00, 3'd0, 5'd1, 32'sd0));
		send_request(make_req(clws_pkg::KIND_CURSOR, 8'h00, 3'd5, 5'd3, 32'sd0));
		send_request(make_req(clws_pkg::KIND_CURSOR, 8'h00, 3'd1, 5'd0, 32'sd0));
		send_request(make_req(clws_pkg::KIND_CURSOR, 8'h00, 3'd4, 5'd21, 32'sd0));
		send_request(make_req(clws_pkg::KIND_CURSOR, 8'h00, 3'd7, 5'd31, 32'sd0));
		// Integers: zero, single digit, sign, both ends of the range and
		// digit-count boundaries.
		send_request(make_req(clws_pkg::KIND_NUMBER, 8'h00, 3'd0, 5'd0, 32'sd0));
		send_request(make_req(clws_pkg::KIND_NUMBER, 8'hFF, 3'd7, 5'd31, -32'sd1));
		send_request(make_req(clws_pkg::KIND_NUMBER, 8'h00, 3'd0, 5'd0, 32'sd7));
		send_request(make_req(clws_pkg::KIND_NUMBER, 8'h00, 3'd0, 5'd0, 32'sd10));
		send_request(make_req(clws_pkg::KIND_NUMBER, 8'h00, 3'd0, 5'd0, 32'sh7FFFFFFF));
		send_request(make_req(clws_pkg::KIND_NUMBER, 8'h00, 3'd0, 5'd0, 32'sh80000000));
		send_request(make_req(clws_pkg::KIND_NUMBER, 8'h00, 3'd0, 5'd0, 32'sd1000000000));
		send_request(make_req(clws_pkg::KIND_NUMBER, 8'h00, 3'd0, 5'd0, -32'sd999999999));
		drain();

		// Nibble bus with a written pulse length of zero (held as one tick).
		write_reg(clws_pkg::REG_BUS_MODE, 24'd1);
		write_reg(clws_pkg::REG_PULSE_TICKS, 24'd0);
		send_random(100);
		drain();

		// Byte bus, longest pulse; receiver holds off for a long stretch while
		// requests keep coming, so the block backs up and stalls its input.
		write_reg(clws_pkg::REG_BUS_MODE, 24'd0);
		write_reg(clws_pkg::REG_PULSE_TICKS, 24'hFFFFFF);
		hold_request = 1'b1;
		send_random(100);
		drain();

		// Nibble bus, shortest nonzero pulse; junk in the upper mode bits.
		write_reg(clws_pkg::REG_BUS_MODE, 24'hFFFFFF);
		write_reg(clws_pkg::REG_PULSE_TICKS, 24'd1);
		send_random(100);
		drain();

		// Last part: random settings, both sides at full rate.
		write_reg(clws_pkg::REG_BUS_MODE, 24'($urandom_range(0, 1)));
		write_reg(clws_pkg::REG_PULSE_TICKS, 24'($urandom_range(2, 24'hFFFFFE)));
		no_idle = 1'b1;
		send_random(120);
		drain();

		// Any stray beat after the last expected one is caught by the receiver.
		repeat (TAIL_WAIT) @(posedge clk);
		if (book.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
